// ===== sv/sdfa_pkg.sv =====
package sdfa_pkg;

  localparam int DefFracBits = 16;

  // operand widths of the shared bit-serial multiplier
  localparam int MulAW = 34;
  localparam int MulBW = 32;
  localparam int MulPW = MulAW + MulBW;

  localparam int DivNW = 64;
  localparam int DivDW = 32;

  localparam int SqrtRW = 64;
  localparam int SqrtQW = 32;

  localparam int AccW = 48;

  localparam logic [31:0] Sqrt2Q30 = 32'd1518500250;

  localparam logic [7:0] REG_STIFFNESS = 8'd0;
  localparam logic [7:0] REG_REST      = 8'd1;
  localparam logic [7:0] REG_DAMPING   = 8'd2;

endpackage

// ===== sv/sdfa_mul.sv =====
module sdfa_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start_i,
  input  logic [sdfa_pkg::MulAW-1:0]  a_i,
  input  logic [sdfa_pkg::MulBW-1:0]  b_i,
  output logic                        done_o,
  output logic [sdfa_pkg::MulPW-1:0]  prod_o
);
  import sdfa_pkg::*;

  logic              busy_r;
  logic [5:0]        cnt_r;
  logic [MulAW-1:0]  a_r;
  logic [MulPW-1:0]  p_r;
  logic [MulAW:0]    sum;

  // shift-add, one multiplier bit per cycle, LSB first
  assign sum = {1'b0, p_r[MulPW-1:MulBW]} + (p_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'(MulBW);
    end else if (busy_r && cnt_r != '0) begin
      cnt_r <= cnt_r - 6'd1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      a_r <= a_i;
      p_r <= {{MulAW{1'b0}}, b_i};
    end else if (busy_r && cnt_r != '0) begin
      p_r <= {sum, p_r[MulBW-1:1]};
    end
  end

  assign done_o = busy_r && (cnt_r == '0);
  assign prod_o = p_r;

endmodule

// ===== sv/sdfa_div.sv =====
module sdfa_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start_i,
  input  logic [sdfa_pkg::DivNW-1:0]  num_i,
  input  logic [sdfa_pkg::DivDW-1:0]  den_i,
  output logic                        done_o,
  output logic [sdfa_pkg::DivNW-1:0]  quot_o
);
  import sdfa_pkg::*;

  logic              busy_r;
  logic [6:0]        cnt_r;
  logic [DivNW-1:0]  num_r;
  logic [DivDW-1:0]  den_r;
  logic [DivDW-1:0]  rem_r;
  logic [DivDW:0]    r2;
  logic [DivDW:0]    diff;
  logic              fits;

  // restoring division, quotient bits shift in behind the dividend
  assign r2   = {rem_r, num_r[DivNW-1]};
  assign diff = r2 - {1'b0, den_r};
  assign fits = r2 >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      cnt_r  <= 7'(DivNW);
    end else if (busy_r && cnt_r != '0) begin
      cnt_r <= cnt_r - 7'd1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      num_r <= num_i;
      den_r <= den_i;
      rem_r <= '0;
    end else if (busy_r && cnt_r != '0) begin
      num_r <= {num_r[DivNW-2:0], fits};
      rem_r <= fits ? diff[DivDW-1:0] : r2[DivDW-1:0];
    end
  end

  assign done_o = busy_r && (cnt_r == '0);
  assign quot_o = num_r;

endmodule

// ===== sv/sdfa_sqrt.sv =====
module sdfa_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start_i,
  input  logic [sdfa_pkg::SqrtRW-1:0]  rad_i,
  output logic                         done_o,
  output logic [sdfa_pkg::SqrtQW-1:0]  root_o
);
  import sdfa_pkg::*;

  logic               busy_r;
  logic [5:0]         cnt_r;
  logic [SqrtRW-1:0]  rad_r;
  logic [SqrtQW+1:0]  rem_r;
  logic [SqrtQW-1:0]  root_r;
  logic [SqrtQW+3:0]  rem2;
  logic [SqrtQW+3:0]  trial;
  logic               fits;

  // two radicand bits per step, one root bit out
  assign rem2  = {rem_r, rad_r[SqrtRW-1:SqrtRW-2]};
  assign trial = {2'b00, root_r, 2'b01};
  assign fits  = rem2 >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'(SqrtQW);
    end else if (busy_r && cnt_r != '0) begin
      cnt_r <= cnt_r - 6'd1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      rad_r  <= rad_i;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r && cnt_r != '0) begin
      rad_r  <= {rad_r[SqrtRW-3:0], 2'b00};
      rem_r  <= fits ? (SqrtQW+2)'(rem2 - trial) : rem2[SqrtQW+1:0];
      root_r <= {root_r[SqrtQW-2:0], fits};
    end
  end

  assign done_o = busy_r && (cnt_r == '0);
  assign root_o = root_r;

endmodule

// ===== sv/spring_damper_force_accumulator.sv =====
// Net force on one lattice node, one neighbor per input request. Each request
// runs through a bit-serial multiplier, a 64-step restoring divider and a
// 32-step square root, all shared and used one after another. A diagonal
// neighbor takes one more product, and one at zero distance skips the
// spring products and the divisions.
// in_stall stays high while a request is in work. The request with
// in_last_neighbor set produces one result (force x/y, Q32.16 saturated,
// plus the zero-length and saturation flags) and clears the accumulators;
// a new request is taken while that result still waits on out_stall.
module spring_damper_force_accumulator #(
  parameter int FRAC_BITS = sdfa_pkg::DefFracBits
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_delta_x,
  input  logic signed [31:0] in_delta_y,
  input  logic signed [31:0] in_rel_vel_x,
  input  logic signed [31:0] in_rel_vel_y,
  input  logic               in_diagonal,
  input  logic               in_last_neighbor,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] out_force_x,
  output logic signed [47:0] out_force_y,
  output logic               out_zero_length_seen,
  output logic               out_saturated
);
  import sdfa_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_SQX   = 14'b00000000000010,
    S_SQY   = 14'b00000000000100,
    S_ROOT  = 14'b00000000001000,
    S_REST  = 14'b00000000010000,
    S_NUMX  = 14'b00000000100000,
    S_DIVX  = 14'b00000001000000,
    S_KX    = 14'b00000010000000,
    S_NUMY  = 14'b00000100000000,
    S_DIVY  = 14'b00001000000000,
    S_KY    = 14'b00010000000000,
    S_DAMPX = 14'b00100000000000,
    S_DAMPY = 14'b01000000000000,
    S_FIN   = 14'b10000000000000
  } state_t;

  typedef struct packed {
    logic             sat;
    logic [AccW-1:0]  val;
  } acc_res_t;

  localparam logic signed [AccW:0] Max48 = {2'b00, {(AccW-1){1'b1}}};
  localparam logic signed [AccW:0] Min48 = {2'b11, {(AccW-1){1'b0}}};

  // clip a signed term to 48 bits, add it, clip the sum again
  function automatic acc_res_t acc_add(input logic [AccW-1:0] acc, input logic neg,
                                       input logic [MulPW-1:0] mag);
    logic signed [AccW:0] term;
    logic signed [AccW:0] s;
    logic                 sat;
    acc_res_t             r;
    sat = 1'b0;
    if (!neg) begin
      if (mag > MulPW'(Max48)) begin
        term = Max48;
        sat  = 1'b1;
      end else begin
        term = mag[AccW:0];
      end
    end else begin
      if (mag > (MulPW'(1) << (AccW-1))) begin
        term = Min48;
        sat  = 1'b1;
      end else begin
        term = -$signed(mag[AccW:0]);
      end
    end
    s = $signed({acc[AccW-1], acc}) + term;
    if (s[AccW] != s[AccW-1]) begin
      r.sat = 1'b1;
      r.val = s[AccW] ? Min48[AccW-1:0] : Max48[AccW-1:0];
    end else begin
      r.sat = sat;
      r.val = s[AccW-1:0];
    end
    return r;
  endfunction

  state_t state_r, state_nxt;
  logic go_r, go_nxt;

  logic [31:0] k_r, d_r, eta_r;

  logic signed [31:0] dx_r, dy_r, vx_r, vy_r;
  logic diag_r, last_r;

  logic [63:0] sq_r, sq_nxt;
  logic [31:0] len_r, len_nxt;
  logic [32:0] rest_r, rest_nxt;
  logic [63:0] num_r, num_nxt;
  logic [33:0] q_r, q_nxt;

  logic [AccW-1:0] acc_x_r, acc_x_nxt, acc_y_r, acc_y_nxt;
  logic zflag_r, zflag_nxt, sflag_r, sflag_nxt;

  logic out_valid_r;
  logic [AccW-1:0] out_fx_r, out_fy_r;
  logic out_z_r, out_s_r;
  logic out_load;

  logic [31:0] mdx, mdy, mvx, mvy;
  logic signed [33:0] diff;
  logic [33:0] mdiff;

  logic mul_start, div_start, sqrt_start;
  logic mul_done, div_done, sqrt_done;
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [MulPW-1:0] prod;
  logic [MulPW-1:0] prod_sh;
  logic [MulPW-1:0] rest_sum;
  logic [DivNW-1:0] quot;
  logic [SqrtQW-1:0] root;
  acc_res_t ar;

  assign mdx = dx_r[31] ? 32'(-dx_r) : 32'(dx_r);
  assign mdy = dy_r[31] ? 32'(-dy_r) : 32'(dy_r);
  assign mvx = vx_r[31] ? 32'(-vx_r) : 32'(vx_r);
  assign mvy = vy_r[31] ? 32'(-vy_r) : 32'(vy_r);
  assign diff  = $signed({2'b00, len_r}) - $signed({1'b0, rest_r});
  assign mdiff = diff[33] ? 34'(-diff) : 34'(diff);

  assign prod_sh  = diag_r ? (prod >> (FRAC_BITS + 1)) : (prod >> FRAC_BITS);
  assign rest_sum = prod + (MulPW'(1) << 29);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQX:   begin mul_a = MulAW'(mdx);   mul_b = mdx;      end
      S_SQY:   begin mul_a = MulAW'(mdy);   mul_b = mdy;      end
      S_REST:  begin mul_a = MulAW'(d_r);   mul_b = Sqrt2Q30; end
      S_NUMX:  begin mul_a = mdiff;         mul_b = mdx;      end
      S_NUMY:  begin mul_a = mdiff;         mul_b = mdy;      end
      S_KX:    begin mul_a = q_r;           mul_b = k_r;      end
      S_KY:    begin mul_a = q_r;           mul_b = k_r;      end
      S_DAMPX: begin mul_a = MulAW'(mvx);   mul_b = eta_r;    end
      S_DAMPY: begin mul_a = MulAW'(mvy);   mul_b = eta_r;    end
      default: begin mul_a = '0;            mul_b = '0;       end
    endcase
  end

  assign mul_start = !go_r && (state_r == S_SQX || state_r == S_SQY ||
                     (state_r == S_REST && diag_r) || state_r == S_NUMX ||
                     state_r == S_NUMY || state_r == S_KX || state_r == S_KY ||
                     state_r == S_DAMPX || state_r == S_DAMPY);
  assign div_start  = !go_r && (state_r == S_DIVX || state_r == S_DIVY);
  assign sqrt_start = !go_r && (state_r == S_ROOT);

  sdfa_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  sdfa_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .num_i   (num_r),
    .den_i   (len_r),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  sdfa_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (sqrt_start),
    .rad_i   (sq_r),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_FIN) && last_r && !(out_valid_r && out_stall);

  always_comb begin
    state_nxt = state_r;
    go_nxt    = go_r;
    sq_nxt    = sq_r;
    len_nxt   = len_r;
    rest_nxt  = rest_r;
    num_nxt   = num_r;
    q_nxt     = q_r;
    acc_x_nxt = acc_x_r;
    acc_y_nxt = acc_y_r;
    zflag_nxt = zflag_r;
    sflag_nxt = sflag_r;
    ar        = '0;
    if (mul_start || div_start || sqrt_start) begin
      go_nxt = 1'b1;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SQX;
        end
      end
      S_SQX: begin
        if (mul_done) begin
          sq_nxt    = prod[63:0];
          go_nxt    = 1'b0;
          state_nxt = S_SQY;
        end
      end
      S_SQY: begin
        if (mul_done) begin
          sq_nxt    = sq_r + prod[63:0];
          go_nxt    = 1'b0;
          state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        if (sqrt_done) begin
          len_nxt   = root;
          go_nxt    = 1'b0;
          state_nxt = S_REST;
        end
      end
      S_REST: begin
        if (!diag_r || mul_done) begin
          rest_nxt  = diag_r ? rest_sum[62:30] : {1'b0, d_r};
          go_nxt    = 1'b0;
          if (len_r == '0) begin
            zflag_nxt = 1'b1;
            state_nxt = S_DAMPX;
          end else begin
            state_nxt = S_NUMX;
          end
        end
      end
      S_NUMX, S_NUMY: begin
        if (mul_done) begin
          num_nxt   = prod[63:0];
          go_nxt    = 1'b0;
          state_nxt = (state_r == S_NUMX) ? S_DIVX : S_DIVY;
        end
      end
      S_DIVX, S_DIVY: begin
        if (div_done) begin
          q_nxt     = quot[33:0];
          go_nxt    = 1'b0;
          state_nxt = (state_r == S_DIVX) ? S_KX : S_KY;
        end
      end
      S_KX: begin
        if (mul_done) begin
          ar        = acc_add(acc_x_r, diff[33] ^ dx_r[31], prod_sh);
          acc_x_nxt = ar.val;
          sflag_nxt = sflag_r | ar.sat;
          go_nxt    = 1'b0;
          state_nxt = S_NUMY;
        end
      end
      S_KY: begin
        if (mul_done) begin
          ar        = acc_add(acc_y_r, diff[33] ^ dy_r[31], prod_sh);
          acc_y_nxt = ar.val;
          sflag_nxt = sflag_r | ar.sat;
          go_nxt    = 1'b0;
          state_nxt = S_DAMPX;
        end
      end
      S_DAMPX: begin
        if (mul_done) begin
          ar        = acc_add(acc_x_r, !vx_r[31] && vx_r != '0, prod_sh);
          acc_x_nxt = ar.val;
          sflag_nxt = sflag_r | ar.sat;
          go_nxt    = 1'b0;
          state_nxt = S_DAMPY;
        end
      end
      S_DAMPY: begin
        if (mul_done) begin
          ar        = acc_add(acc_y_r, !vy_r[31] && vy_r != '0, prod_sh);
          acc_y_nxt = ar.val;
          sflag_nxt = sflag_r | ar.sat;
          go_nxt    = 1'b0;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (out_load) begin
          acc_x_nxt = '0;
          acc_y_nxt = '0;
          zflag_nxt = 1'b0;
          sflag_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        go_nxt    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      go_r        <= 1'b0;
      k_r         <= 32'(1) << FRAC_BITS;
      d_r         <= 32'(1) << FRAC_BITS;
      eta_r       <= '0;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      zflag_r     <= 1'b0;
      sflag_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
      acc_x_r <= acc_x_nxt;
      acc_y_r <= acc_y_nxt;
      zflag_r <= zflag_nxt;
      sflag_r <= sflag_nxt;
      if (cfg_we) begin
        if (cfg_index == REG_STIFFNESS) k_r   <= cfg_wdata;
        if (cfg_index == REG_REST)      d_r   <= cfg_wdata;
        if (cfg_index == REG_DAMPING)   eta_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sq_r   <= sq_nxt;
    len_r  <= len_nxt;
    rest_r <= rest_nxt;
    num_r  <= num_nxt;
    q_r    <= q_nxt;
    if (state_r == S_IDLE && in_valid) begin
      dx_r   <= in_delta_x;
      dy_r   <= in_delta_y;
      vx_r   <= in_rel_vel_x;
      vy_r   <= in_rel_vel_y;
      diag_r <= in_diagonal;
      last_r <= in_last_neighbor;
    end
    if (out_load) begin
      out_fx_r <= acc_x_r;
      out_fy_r <= acc_y_r;
      out_z_r  <= zflag_r;
      out_s_r  <= sflag_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_force_x          = out_fx_r;
  assign out_force_y          = out_fy_r;
  assign out_zero_length_seen = out_z_r;
  assign out_saturated        = out_s_r;

  a_unit_busy_only: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_done || div_done || sqrt_done) |-> state_r != S_IDLE)
    else $error("arithmetic unit finished while idle");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside the final step");

  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (acc_x_r == '0 && acc_y_r == '0 && !zflag_r && !sflag_r))
    else $error("accumulators not cleared after result");

endmodule
